[hdl/text_console_writer_defines.svh]
// Assertion macros shared by the console writer.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tcw_pkg.sv]
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STEP_DEF = 10;

    localparam int REQ_W  = 3;
    localparam int CHAR_W = 8;
    localparam int COLIN_W = 8;
    localparam int RADDR_W = 11;
    localparam int POS_W  = 12;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT    = 3'd0,
        REQ_BS     = 3'd1,
        REQ_TAB    = 3'd2,
        REQ_CLEAR  = 3'd3,
        REQ_SETCOL = 3'd4,
        REQ_READ   = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_CLEAR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scroll_go;
        logic clear_go;
        logic sweep_run;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic needs_scroll;
        logic is_clear;
        logic at_end;
        logic sweep_done;
        logic out_free;
    } status_t;

endpackage

[hdl/text_console_writer.sv]
`timescale 1ns / 1ps
// Channel   Direction  tdata fields (low bit first)                tuser
// s_axis    in         char_code[7:0] column[15:8] read_addr[26:16]  req_type[2:0]
// m_axis    out        cursor_pos[11:0] cell_char[19:12] scrolled[20] -
//
// An ordinary item passes through accept, execute and load; a read takes its cell from the
// store's registered port. A scrolling put or tab adds one sweep of the store, a cell a cycle,
// copying each row up and zeroing the bottom row, then a second execute. Clear runs a sweep
// of the store in place of the execute, zeroing every cell. After reset a clearing pass over
// the store runs with s_axis_tready low. A waiting result holds in the output register while
// the next item is accepted; the one after it stalls.

`include "text_console_writer_defines.svh"

module text_console_writer #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // char_code, column, read_addr
    input  logic [2:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // cursor_pos, cell_char, scrolled
);

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int CELL_AW = $clog2(CELLS);

    tcw_pkg::cmd_t             cmd;
    tcw_pkg::status_t          st;
    logic                      mem_wr_en;
    logic [CELL_AW-1:0]        mem_wr_addr;
    logic [tcw_pkg::CHAR_W-1:0] mem_wr_data;
    logic                      mem_wr_from_rd;
    logic                      mem_rd_en;
    logic [CELL_AW-1:0]        mem_rd_addr;
    logic [tcw_pkg::CHAR_W-1:0] mem_rd_data;
    logic [tcw_pkg::POS_W-1:0] out_pos;
    logic [tcw_pkg::CHAR_W-1:0] out_cell;
    logic                      out_scrolled;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .in_req         (s_axis_tuser),
        .in_char        (s_axis_tdata[7:0]),
        .in_col         (s_axis_tdata[15:8]),
        .in_addr        (s_axis_tdata[26:16]),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_pos        (out_pos),
        .out_cell       (out_cell),
        .out_scrolled   (out_scrolled),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_wr_from_rd (mem_wr_from_rd),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data)
    );

    tcw_screen_mem #(
        .DEPTH (CELLS)
    ) u_screen_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (mem_wr_en),
        .wr_addr    (mem_wr_addr),
        .wr_data    (mem_wr_data),
        .wr_from_rd (mem_wr_from_rd),
        .rd_en      (mem_rd_en),
        .rd_addr    (mem_rd_addr),
        .rd_data    (mem_rd_data)
    );

    assign m_axis_tdata = {3'b000, out_scrolled, out_cell, out_pos};

    `TCW_ASSERT_NOW(a_no_accept_in_sweep, s_axis_tready, !cmd.sweep_run, "accept in sweep")
    `TCW_ASSERT_NOW(a_no_result_overwrite, cmd.load_out, st.out_free, "result overwritten")
    `TCW_ASSERT_NEXT(a_scroll_leaves_end, cmd.scroll_go, !st.at_end, "at end after scroll")
    `TCW_ASSERT_NEXT(a_one_item_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy accept")

endmodule

[hdl/tcw_screen_mem.sv]
`timescale 1ns / 1ps

module tcw_screen_mem #(
    parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [tcw_pkg::CHAR_W-1:0]  wr_data,
    input  logic                        wr_from_rd,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [tcw_pkg::CHAR_W-1:0]  rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [tcw_pkg::CHAR_W-1:0] cells_reg [DEPTH];
    logic [tcw_pkg::CHAR_W-1:0] rd_data_reg;
    logic                       wv_reg;
    logic [AW-1:0]              waddr_reg;
    logic [tcw_pkg::CHAR_W-1:0] wdata_reg;
    logic                       wfrom_reg;

    // Writes land in the cycle after they are issued; a copy takes the last read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg <= 1'b0;
        end
        else
        begin
            wv_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        waddr_reg <= wr_addr;
        wdata_reg <= wr_data;
        wfrom_reg <= wr_from_rd;
        if (wv_reg)
        begin
            cells_reg[waddr_reg] <= wfrom_reg ? rd_data_reg : wdata_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= cells_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/tcw_ctrl.sv]
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tcw_pkg::status_t st,
    output tcw_pkg::cmd_t    cmd
);

    tcw_pkg::state_t state_reg;
    tcw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                cmd.sweep_run = 1'b1;
                if (st.sweep_done)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC:
            begin
                if (st.needs_scroll)
                begin
                    cmd.scroll_go = 1'b1;
                    state_next    = tcw_pkg::ST_SCROLL;
                end
                else if (st.is_clear)
                begin
                    cmd.clear_go = 1'b1;
                    state_next   = tcw_pkg::ST_CLEAR;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = tcw_pkg::ST_RESP;
                end
            end
            tcw_pkg::ST_SCROLL:
            begin
                cmd.sweep_run = 1'b1;
                // back to execute: the request itself still has to be applied
                if (st.sweep_done)
                begin
                    state_next = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_CLEAR:
            begin
                cmd.sweep_run = 1'b1;
                if (st.sweep_done)
                begin
                    state_next = tcw_pkg::ST_RESP;
                end
            end
            tcw_pkg::ST_RESP:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/tcw_datapath.sv]
`timescale 1ns / 1ps

module tcw_datapath #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tcw_pkg::cmd_t                         cmd,
    output tcw_pkg::status_t                      st,
    input  logic [tcw_pkg::REQ_W-1:0]             in_req,
    input  logic [tcw_pkg::CHAR_W-1:0]            in_char,
    input  logic [tcw_pkg::COLIN_W-1:0]           in_col,
    input  logic [tcw_pkg::RADDR_W-1:0]           in_addr,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [tcw_pkg::POS_W-1:0]             out_pos,
    output logic [tcw_pkg::CHAR_W-1:0]            out_cell,
    output logic                                  out_scrolled,
    output logic                                  mem_wr_en,
    output logic [$clog2(COLUMNS*ROWS)-1:0]       mem_wr_addr,
    output logic [tcw_pkg::CHAR_W-1:0]            mem_wr_data,
    output logic                                  mem_wr_from_rd,
    output logic                                  mem_rd_en,
    output logic [$clog2(COLUMNS*ROWS)-1:0]       mem_rd_addr,
    input  logic [tcw_pkg::CHAR_W-1:0]            mem_rd_data
);

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int OFF_W   = $clog2(CELLS + 1);
    localparam int ROW_W   = $clog2(ROWS + 1);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int CW      = tcw_pkg::CHAR_W;

    localparam logic [OFF_W-1:0]   COLS_OFF  = OFF_W'(COLUMNS);
    localparam logic [OFF_W-1:0]   TAB_OFF   = OFF_W'(TAB_STEP);
    localparam logic [OFF_W-1:0]   LAST_ROW  = OFF_W'(CELLS - COLUMNS);
    localparam logic [ROW_W-1:0]   ROWS_R    = ROW_W'(ROWS);
    localparam logic [COL_W-1:0]   COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [COL_W:0]     COLS_X    = (COL_W + 1)'(COLUMNS);
    localparam logic [COL_W:0]     TAB_X     = (COL_W + 1)'(TAB_STEP);
    localparam logic [tcw_pkg::COLIN_W:0] COLS_IN = (tcw_pkg::COLIN_W + 1)'(COLUMNS);
    localparam logic [CELL_AW-1:0] SWP_LAST  = CELL_AW'(CELLS - 1);
    localparam logic [CELL_AW-1:0] SWP_COPY  = CELL_AW'(CELLS - COLUMNS);
    localparam logic [CELL_AW-1:0] COLS_A    = CELL_AW'(COLUMNS);

    logic [tcw_pkg::REQ_W-1:0]   req_reg;
    logic [CW-1:0]               char_reg;
    logic [tcw_pkg::COLIN_W-1:0] colin_reg;
    logic                        rhit_reg;
    logic [CELL_AW-1:0]          raddr_reg;
    logic [ROW_W-1:0]            row_reg, row_next;
    logic [COL_W-1:0]            col_reg, col_next;
    logic [OFF_W-1:0]            off_reg, off_next;
    logic                        scr_reg, scr_next;
    logic [CELL_AW-1:0]          sweep_reg, sweep_next;
    logic                        copy_reg, copy_next;
    logic                        ov_reg;
    logic [tcw_pkg::POS_W-1:0]   opos_reg;
    logic [CW-1:0]               ocell_reg;
    logic                        oscr_reg;

    logic                        at_end;
    logic                        put_real;
    logic [OFF_W-1:0]            off_rs;
    logic [OFF_W-1:0]            off_nl;
    logic [OFF_W-1:0]            off_bs;
    logic [COL_W:0]              tab_sum;
    logic [tcw_pkg::COLIN_W:0]   colin_x;
    logic [tcw_pkg::RADDR_W+CELL_AW-1:0] addr_ext;
    logic [OFF_W+tcw_pkg::POS_W-1:0]     pos_ext;
    logic                        out_free;

    assign at_end   = (row_reg == ROWS_R);
    assign put_real = (char_reg != '0);
    assign off_rs   = off_reg - OFF_W'(col_reg);
    assign off_nl   = off_rs + COLS_OFF;
    assign off_bs   = (off_reg != '0) ? (off_reg - OFF_W'(1)) : off_reg;
    assign tab_sum  = {1'b0, col_reg} + TAB_X;
    assign colin_x  = {1'b0, colin_reg};
    assign addr_ext = {{CELL_AW{1'b0}}, in_addr};
    assign pos_ext  = {{tcw_pkg::POS_W{1'b0}}, off_reg};
    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        st.at_end       = at_end;
        st.needs_scroll = at_end && (((req_reg == tcw_pkg::REQ_PUT) && put_real)
                                     || (req_reg == tcw_pkg::REQ_TAB));
        st.is_clear     = (req_reg == tcw_pkg::REQ_CLEAR);
        st.sweep_done   = (sweep_reg == SWP_LAST);
        st.out_free     = out_free;
    end

    // Scroll sweep: rows up, last row zeroed; others zero all. Commands: at most one cell.
    always_comb
    begin
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = '0;
        mem_wr_from_rd = 1'b0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;
        if (cmd.sweep_run)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_reg;
            if (copy_reg && (sweep_reg < SWP_COPY))
            begin
                mem_wr_from_rd = 1'b1;
                mem_rd_en      = 1'b1;
                mem_rd_addr    = sweep_reg + COLS_A;
            end
        end
        else if (cmd.exec)
        begin
            case (req_reg)
                tcw_pkg::REQ_PUT:
                begin
                    if (put_real && (char_reg != tcw_pkg::NEWLINE_CODE))
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = off_reg[CELL_AW-1:0];
                        mem_wr_data = char_reg;
                    end
                end
                tcw_pkg::REQ_BS:
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = off_bs[CELL_AW-1:0];
                end
                tcw_pkg::REQ_READ:
                begin
                    mem_rd_en   = rhit_reg;
                    mem_rd_addr = raddr_reg;
                end
                default:
                begin
                    mem_rd_en = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        off_next   = off_reg;
        scr_next   = scr_reg;
        sweep_next = sweep_reg;
        copy_next  = copy_reg;
        if (cmd.capture)
        begin
            scr_next = 1'b0;
        end
        if (cmd.sweep_run)
        begin
            sweep_next = (sweep_reg == SWP_LAST) ? '0 : (sweep_reg + CELL_AW'(1));
        end
        if (cmd.scroll_go)
        begin
            row_next   = ROW_W'(ROWS - 1);
            col_next   = '0;
            off_next   = LAST_ROW;
            scr_next   = 1'b1;
            sweep_next = '0;
            copy_next  = 1'b1;
        end
        if (cmd.clear_go)
        begin
            row_next   = '0;
            col_next   = '0;
            off_next   = '0;
            sweep_next = '0;
            copy_next  = 1'b0;
        end
        if (cmd.exec)
        begin
            case (req_reg)
                tcw_pkg::REQ_PUT:
                begin
                    if (char_reg == tcw_pkg::NEWLINE_CODE)
                    begin
                        off_next = off_nl;
                        col_next = '0;
                        row_next = row_reg + ROW_W'(1);
                    end
                    else if (put_real)
                    begin
                        off_next = off_reg + OFF_W'(1);
                        if (col_reg == COL_LAST)
                        begin
                            col_next = '0;
                            row_next = row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                end
                tcw_pkg::REQ_BS:
                begin
                    if (off_reg != '0)
                    begin
                        off_next = off_bs;
                        if (col_reg == '0)
                        begin
                            col_next = COL_LAST;
                            row_next = row_reg - ROW_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg - COL_W'(1);
                        end
                    end
                end
                tcw_pkg::REQ_TAB:
                begin
                    if (tab_sum > COLS_X)
                    begin
                        off_next = off_nl;
                        col_next = '0;
                        row_next = row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        off_next = off_reg + TAB_OFF;
                        if (tab_sum == COLS_X)
                        begin
                            col_next = '0;
                            row_next = row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            col_next = tab_sum[COL_W-1:0];
                        end
                    end
                end
                tcw_pkg::REQ_SETCOL:
                begin
                    // at the end of the screen any column saturates back to the end
                    if (!at_end && (colin_x <= COLS_IN))
                    begin
                        off_next = off_rs + OFF_W'(colin_reg);
                        if (colin_x == COLS_IN)
                        begin
                            col_next = '0;
                            row_next = row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            col_next = colin_reg[COL_W-1:0];
                        end
                    end
                end
                default:
                begin
                    off_next = off_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            off_reg   <= '0;
            scr_reg   <= 1'b0;
            sweep_reg <= '0;
            copy_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            off_reg   <= off_next;
            scr_reg   <= scr_next;
            sweep_reg <= sweep_next;
            copy_reg  <= copy_next;
            if (cmd.load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= in_req;
            char_reg  <= in_char;
            colin_reg <= in_col;
            rhit_reg  <= (32'(in_addr) < 32'(CELLS));
            raddr_reg <= addr_ext[CELL_AW-1:0];
        end
        if (cmd.load_out)
        begin
            opos_reg  <= pos_ext[tcw_pkg::POS_W-1:0];
            ocell_reg <= ((req_reg == tcw_pkg::REQ_READ) && rhit_reg) ? mem_rd_data : '0;
            oscr_reg  <= scr_reg;
        end
    end

    assign out_valid    = ov_reg;
    assign out_pos      = opos_reg;
    assign out_cell     = ocell_reg;
    assign out_scrolled = oscr_reg;

endmodule
